/* hw/rtl/lae_pkg.sv */
`default_nettype none

package lae_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_NOTE_LEN      = 3'd4;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_PAST    = 3'd4;

    localparam logic [4:0] SUSTAIN_FULL = 5'd16;

    typedef struct packed {
        logic [7:0] sample_in;
        logic       note_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] sample_out;
        logic [2:0] phase;
        logic       note_last;
    } out_beat_t;

endpackage

`default_nettype wire

/* hw/rtl/linear_adsr_envelope_unit.sv */
`default_nettype none

// Linear ADSR envelope on an unsigned 8-bit stream, one result beat per input
// beat. Gain is an exact ratio: the numerator is built by a bit-serial
// shift-add multiplier (three passes, each ending at the top set bit of its
// multiplier), then a restoring divider yields the quotient one bit per cycle.
// A beat occupies the datapath from acceptance until s_ready returns, longer
// while the output register still holds an unaccepted result; the next beat
// is taken while a finished result still waits in the output register.
// The user must write configuration registers through cfg_wr_en/cfg_index/
// cfg_wdata only while idle; the block itself does not enforce it. Indexes
// past note_len are ignored and sustain_level above 16 reads as 16.

module linear_adsr_envelope_unit (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [lae_pkg::IDX_W-1:0]    cfg_index,
    input  wire [lae_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire lae_pkg::in_beat_t      s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output lae_pkg::out_beat_t          m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [15:0]         attack_reg;
    logic [15:0]         decay_reg;
    logic [4:0]          sustain_reg;
    logic [15:0]         release_reg;
    logic [15:0]         note_reg;
    logic [15:0]         pos_reg;
    logic [15:0]         p_reg;
    logic [7:0]          samp_reg;
    logic [2:0]          phase_reg;
    logic                last_reg;
    logic [27:0]         acc_reg;
    logic [27:0]         mcand_reg;
    logic [7:0]          mplier_reg;
    logic [15:0]         mcand2_reg;
    logic [4:0]          mplier2_reg;
    logic [26:0]         dvs_reg;
    logic [27:0]         rem_reg;
    logic [7:0]          quo_reg;
    logic [2:0]          cnt_reg;
    logic                m_valid_reg;
    lae_pkg::out_beat_t  m_data_reg;

    logic [15:0] p_next;
    logic [16:0] ad_sum;
    logic signed [17:0] sus_end;
    logic        in_attack;
    logic        in_decay;
    logic        in_sustain;
    logic        in_release;
    logic [15:0] dec_rem;
    logic [15:0] rel_rem;
    logic [4:0]  sl_inv;
    logic        note_last;
    logic [27:0] mul_sum;
    logic [7:0]  mplier_shr;
    logic [28:0] div_diff;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= lae_pkg::SUSTAIN_FULL;
            release_reg <= '0;
            note_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lae_pkg::REG_ATTACK_LEN:  attack_reg <= cfg_wdata;
                lae_pkg::REG_DECAY_LEN:   decay_reg  <= cfg_wdata;
                lae_pkg::REG_SUSTAIN_LEVEL: begin
                    sustain_reg <= (cfg_wdata[4:0] > lae_pkg::SUSTAIN_FULL) ?
                                   lae_pkg::SUSTAIN_FULL : cfg_wdata[4:0];
                end
                lae_pkg::REG_RELEASE_LEN: release_reg <= cfg_wdata;
                lae_pkg::REG_NOTE_LEN:    note_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign p_next     = s_data.note_start ? 16'd0 : pos_reg;
    assign ad_sum     = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign sus_end    = $signed({2'b00, note_reg}) - $signed({2'b00, release_reg});
    assign in_attack  = p_reg < attack_reg;
    assign in_decay   = {1'b0, p_reg} < ad_sum;
    assign in_sustain = $signed({2'b00, p_reg}) < sus_end;
    assign in_release = p_reg < note_reg;
    assign dec_rem    = 16'(ad_sum - {1'b0, p_reg});
    assign rel_rem    = note_reg - p_reg;
    assign sl_inv     = lae_pkg::SUSTAIN_FULL - sustain_reg;
    assign note_last  = (note_reg != 16'd0) && (p_reg == note_reg - 16'd1);

    assign mul_sum    = acc_reg + (mplier_reg[0] ? mcand_reg : 28'd0);
    assign mplier_shr = {1'b0, mplier_reg[7:1]};
    assign div_diff   = {1'b0, rem_reg} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        p_reg     <= p_next;
                        samp_reg  <= s_data.sample_in;
                        pos_reg   <= (p_next == 16'hFFFF) ? p_next : p_next + 16'd1;
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    last_reg    <= note_last;
                    acc_reg     <= '0;
                    mcand2_reg  <= '0;
                    mplier2_reg <= '0;
                    if (in_attack) begin
                        phase_reg  <= lae_pkg::PH_ATTACK;
                        mcand_reg  <= {12'd0, p_reg};
                        mplier_reg <= 8'd1;
                        dvs_reg    <= {4'd0, attack_reg, 7'd0};
                    end else if (in_decay) begin
                        phase_reg   <= lae_pkg::PH_DECAY;
                        mcand_reg   <= {12'd0, dec_rem};
                        mplier_reg  <= {3'd0, sl_inv};
                        mcand2_reg  <= decay_reg;
                        mplier2_reg <= sustain_reg;
                        dvs_reg     <= {decay_reg, 4'd0, 7'd0};
                    end else if (in_sustain) begin
                        phase_reg  <= lae_pkg::PH_SUSTAIN;
                        mcand_reg  <= 28'd1;
                        mplier_reg <= {3'd0, sustain_reg};
                        dvs_reg    <= {20'd16, 7'd0};
                    end else if (in_release) begin
                        phase_reg  <= lae_pkg::PH_RELEASE;
                        mcand_reg  <= {12'd0, rel_rem};
                        mplier_reg <= {3'd0, sustain_reg};
                        dvs_reg    <= {release_reg, 4'd0, 7'd0};
                    end else begin
                        phase_reg  <= lae_pkg::PH_PAST;
                        mcand_reg  <= 28'd1;
                        mplier_reg <= 8'd1;
                        dvs_reg    <= {20'd1, 7'd0};
                    end
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    acc_reg <= mul_sum;
                    if (mplier_shr == 8'd0) begin
                        mcand_reg  <= {12'd0, mcand2_reg};
                        mplier_reg <= {3'd0, mplier2_reg};
                        state_reg  <= S_MUL2;
                    end else begin
                        mcand_reg  <= {mcand_reg[26:0], 1'b0};
                        mplier_reg <= mplier_shr;
                    end
                end
                S_MUL2: begin
                    if (mplier_shr == 8'd0) begin
                        // numerator ratio done, now scale by the sample
                        acc_reg    <= '0;
                        mcand_reg  <= mul_sum;
                        mplier_reg <= samp_reg;
                        state_reg  <= S_MUL3;
                    end else begin
                        acc_reg    <= mul_sum;
                        mcand_reg  <= {mcand_reg[26:0], 1'b0};
                        mplier_reg <= mplier_shr;
                    end
                end
                S_MUL3: begin
                    if (mplier_shr == 8'd0) begin
                        rem_reg   <= mul_sum;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        acc_reg    <= mul_sum;
                        mcand_reg  <= {mcand_reg[26:0], 1'b0};
                        mplier_reg <= mplier_shr;
                    end
                end
                S_DIV: begin
                    if (!div_diff[28]) begin
                        rem_reg <= div_diff[27:0];
                    end
                    quo_reg <= {quo_reg[6:0], ~div_diff[28]};
                    dvs_reg <= {1'b0, dvs_reg[26:1]};
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.sample_out <= quo_reg;
                        m_data_reg.phase      <= phase_reg;
                        m_data_reg.note_last  <= last_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in progress");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < {1'b0, dvs_reg, 1'b0}))
        else $error("divider remainder out of range");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.phase <= lae_pkg::PH_PAST))
        else $error("phase code out of range");

    a_last_in_note: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.note_last) |-> (m_data.phase != lae_pkg::PH_PAST))
        else $error("last sample of note flagged past note end");
`endif

endmodule

`default_nettype wire

/* verif/linear_adsr_envelope_unit_tb.sv */
`default_nettype none

module linear_adsr_envelope_unit_tb;

    localparam int unsigned STUCK_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_PHASES = 18;
    localparam int unsigned PHASE_BEATS = 130;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [lae_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [lae_pkg::CFG_W-1:0]  cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    lae_pkg::in_beat_t          s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    lae_pkg::out_beat_t         m_data;

    linear_adsr_envelope_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register mirror and envelope position
    logic [15:0] atk_len = 16'd0;
    logic [15:0] dcy_len = 16'd0;
    logic [4:0]  sus_lvl = lae_pkg::SUSTAIN_FULL;
    logic [15:0] rel_len = 16'd0;
    logic [15:0] note_length = 16'd0;
    logic [15:0] env_pos = 16'd0;

    lae_pkg::in_beat_t    pend_samples[$];
    lae_pkg::out_beat_t   predicted_out[$];

    int unsigned snd_idle_pct = 24;
    int unsigned rcv_idle_pct = 45;
    int unsigned hold_ask_cnt = 0;
    int unsigned hold_done_cnt = 0;
    int unsigned hold_left = 0;
    int unsigned stuck_cycles = 0;
    int unsigned mismatches = 0;
    logic        s_took = 1'b0;

    function automatic lae_pkg::out_beat_t envelope_predict(input lae_pkg::in_beat_t b);
        longint unsigned s, p, a, d, r, l, sl, num, res;
        longint          sus_end;
        lae_pkg::out_beat_t o;
        s = b.sample_in;
        p = b.note_start ? 0 : env_pos;
        a = atk_len;
        d = dcy_len;
        r = rel_len;
        l = note_length;
        sl = (sus_lvl > lae_pkg::SUSTAIN_FULL) ? 16 : sus_lvl;
        sus_end = longint'(l) - longint'(r);
        if (p < a) begin
            res = (s * p) / a;
            o.phase = lae_pkg::PH_ATTACK;
        end else if (p < a + d) begin
            num = (a + d - p) * (16 - sl) + sl * d;
            res = (s * num) / (16 * d);
            o.phase = lae_pkg::PH_DECAY;
        end else if (longint'(p) < sus_end) begin
            res = (s * sl) / 16;
            o.phase = lae_pkg::PH_SUSTAIN;
        end else if (p < l) begin
            res = (s * sl * (l - p)) / (16 * r);
            o.phase = lae_pkg::PH_RELEASE;
        end else begin
            res = s;
            o.phase = lae_pkg::PH_PAST;
        end
        o.sample_out = res[7:0];
        o.note_last = (l != 0) && (p == l - 1);
        env_pos = (p < 64'hFFFF) ? 16'(p + 1) : 16'(p);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (pend_samples.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pend_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_done_cnt != hold_ask_cnt) begin
            hold_done_cnt++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // input beat capture, result checking, watchdog
    always @(posedge aclk) begin
        lae_pkg::out_beat_t want;
        s_took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            predicted_out.push_back(envelope_predict(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (predicted_out.size() == 0) begin
                $display("%0t: unexpected result beat: actual %p", $time, m_data);
                mismatches++;
            end else begin
                want = predicted_out.pop_front();
                check_field("sample_out", want.sample_out, m_data.sample_out);
                check_field("phase", 8'(want.phase), 8'(m_data.phase));
                check_field("note_last", 8'(want.note_last), 8'(m_data.note_last));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stuck_cycles);
            $display("linear_adsr_envelope_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [lae_pkg::IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            lae_pkg::REG_ATTACK_LEN:    atk_len = val;
            lae_pkg::REG_DECAY_LEN:     dcy_len = val;
            lae_pkg::REG_SUSTAIN_LEVEL: sus_lvl = val[4:0];
            lae_pkg::REG_RELEASE_LEN:   rel_len = val;
            lae_pkg::REG_NOTE_LEN:      note_length = val;
            default: ;
        endcase
    endtask

    task automatic set_envelope(input logic [15:0] a, input logic [15:0] d,
                                input logic [4:0] s, input logic [15:0] r,
                                input logic [15:0] l);
        write_reg(lae_pkg::REG_ATTACK_LEN, a);
        write_reg(lae_pkg::REG_DECAY_LEN, d);
        write_reg(lae_pkg::REG_SUSTAIN_LEVEL, 16'(s));
        write_reg(lae_pkg::REG_RELEASE_LEN, r);
        write_reg(lae_pkg::REG_NOTE_LEN, l);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_sample(input logic [7:0] smp, input logic st);
        lae_pkg::in_beat_t b;
        b.sample_in = smp;
        b.note_start = st;
        pend_samples.push_back(b);
    endtask

    task automatic wait_idle();
        while (pend_samples.size() != 0 || s_valid || predicted_out.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] rand_len(input int unsigned top);
        if ($urandom_range(4) == 0)
            return 16'd0;
        return 16'($urandom_range(top, 1));
    endfunction

    // mostly whole notes with random content, some cut short or restarted early
    task automatic queue_notes(input int unsigned n);
        int unsigned cnt, len, k;
        logic        st;
        cnt = 0;
        while (cnt < n) begin
            if (note_length > 40)
                len = $urandom_range(40, 4);
            else
                len = note_length + $urandom_range(4);
            if ($urandom_range(9) == 0)
                len = $urandom_range(len, 1);
            if (len == 0)
                len = 1;
            for (k = 0; k < len; k++) begin
                st = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) < 3);
                push_sample(rand_sample(), st);
                cnt++;
            end
        end
    endtask

    initial begin
        int unsigned ph, k;
        logic [4:0]  sl;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty note, everything passes through
        push_sample(8'h00, 1'b1);
        push_sample(8'hFF, 1'b0);
        push_sample(8'hAA, 1'b0);
        wait_idle();

        // one note through every region
        set_envelope(16'd4, 16'd4, 5'd8, 16'd4, 16'd16);
        push_sample(8'hFF, 1'b1);
        for (k = 1; k < 17; k++)
            push_sample((k % 5 == 0) ? 8'h80 : 8'hFF, 1'b0);
        wait_idle();

        // sustain level saturated, release longer than the note
        set_envelope(16'd0, 16'd2, 5'd31, 16'd20, 16'd10);
        push_sample(8'hFF, 1'b1);
        for (k = 1; k < 5; k++)
            push_sample(8'hFF, 1'b0);
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES / 3) begin
                snd_idle_pct = 45;
                rcv_idle_pct = 24;
            end else if (ph == 2 * RAND_PHASES / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (ph % 6)
                0: set_envelope(16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF, 16'hFFFF);
                1: set_envelope(16'd0, 16'hFFFF, 5'd0, 16'd0, 16'hFFFF);
                2: set_envelope(16'd0, 16'd0, lae_pkg::SUSTAIN_FULL, 16'hFFFF, 16'hFFFF);
                default: begin
                    sl = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 17))
                                                  : 5'($urandom_range(16));
                    set_envelope(rand_len(12), rand_len(12), sl, rand_len(12), rand_len(48));
                end
            endcase
            queue_notes((ph % 6 < 3) ? 30 : PHASE_BEATS);
            if (ph % 6 == 4) begin
                @(posedge aclk);
                hold_ask_cnt++;
            end
            wait_idle();
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("linear_adsr_envelope_unit_tb: PASS");
        else
            $display("linear_adsr_envelope_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
